FILE: sv/gb2d_pkg.sv
// Shared types and constants for the windowed Gaussian blur block.
`default_nettype none
package gb2d_pkg;

	localparam int CHAN_W   = 8;
	localparam int LANES    = 4;
	localparam int PIX_W    = CHAN_W * LANES;
	localparam int WGT_W    = 17;
	localparam int WT_W     = 2 * WGT_W;
	localparam int PROD_W   = WT_W + CHAN_W;
	localparam int ROW_W    = 12;
	localparam int FW_W     = 11;
	localparam int CH_W     = 3;
	localparam int RAD_W    = 2;
	localparam int FRAC_W   = 32;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_KERNEL_RADIUS = 3'd3,
		REG_WEIGHT_ZERO   = 3'd4,
		REG_WEIGHT_ONE    = 3'd5,
		REG_WEIGHT_TWO    = 3'd6,
		REG_WEIGHT_THREE  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan_a;
		logic [CHAN_W-1:0] chan_b;
		logic [CHAN_W-1:0] chan_c;
		logic [CHAN_W-1:0] chan_d;
		logic              flush;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blur_a;
		logic [CHAN_W-1:0] blur_b;
		logic [CHAN_W-1:0] blur_c;
		logic [CHAN_W-1:0] blur_d;
		logic              end_of_frame;
	} out_item_t;

endpackage
`default_nettype wire

FILE: sv/gb2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gb2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/gaussian_blur_2d_window_top.sv
// Top level of the streaming 2D Gaussian blur over a raster-order pixel stream.
//
// Pixels enter on the pix channel (valid/ready) one beat per pixel, in raster
// order; a beat with flush set carries no pixel and only drains one pending
// output at the end of a frame. Every input beat gives zero or one beat on the
// blur channel (valid/ready), which carries the filtered channels and marks the
// frame's last pixel with end_of_frame.
// Each pixel is written to a ring of line stores held in one synchronous RAM.
// When the window around the next output position is complete, the block reads
// the centre pixel and then every tap of the (2R+1) x (2R+1) window from that
// RAM, one tap per cycle through its single read port, and accumulates the
// weighted channels in a short multiply pipeline.
// No new input beat is taken until the current one is finished, since pix_ready
// is high only in the idle state; a beat that gives a result holds off further
// beats while its window is read through the one read port of the line RAM.
// The finished result sits in an output register, so the next input beat is
// taken while that result still waits for the receiver. If the receiver stalls
// longer, the following result waits in the final state until the register
// frees, and no new input beat is taken meanwhile.
// Reset sets the registers to their defaults and all positions to the frame
// start; the line RAM is not cleared, since only pixels of the current frame
// are ever read. A register write also restarts the frame.
`default_nettype none
module gaussian_blur_2d_window_top #(
	parameter int MAX_RADIUS   = 3,
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_CHANNELS = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pix_valid,
	output logic                                  pix_ready,
	input  wire gb2d_pkg::in_item_t               pix,
	output logic                                  blur_valid,
	input  wire logic                             blur_ready,
	output gb2d_pkg::out_item_t                   blur,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [gb2d_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [gb2d_pkg::DATA_W-1:0]      pwdata,
	output logic      [gb2d_pkg::DATA_W-1:0]      prdata,
	output logic                                  pready
);

	localparam int RING  = 2 * MAX_RADIUS + 2;
	localparam int RW    = $clog2(RING);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH = RING * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = $clog2(MAX_RADIUS + 1) + 2;
	localparam int RGW   = DW + 1;
	localparam int TRW   = gb2d_pkg::ROW_W + 2;
	localparam int TCW   = WW + 2;
	localparam int NW    = gb2d_pkg::ROW_W + 1;
	localparam int ACC_W = gb2d_pkg::PROD_W + $clog2((2 * MAX_RADIUS + 1) ** 2) + 1;
	localparam int LN    = gb2d_pkg::LANES;
	localparam int CHW   = gb2d_pkg::CHAN_W;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_CTR   = 6'b000100,
		S_RUN   = 6'b001000,
		S_DRAIN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	// Configuration registers.
	logic [gb2d_pkg::FW_W-1:0]  width_q;
	logic [gb2d_pkg::ROW_W-1:0] height_q;
	logic [gb2d_pkg::CH_W-1:0]  chans_q;
	logic [gb2d_pkg::RAD_W-1:0] radius_q;
	logic [gb2d_pkg::WGT_W-1:0] weight_zero_q, weight_one_q, weight_two_q, weight_three_q;

	// Positions.
	logic [CW-1:0]              in_col_q, out_col_q;
	logic [gb2d_pkg::ROW_W-1:0] in_row_q, out_row_q;
	logic [RW-1:0]              in_ring_q, out_ring_q;

	state_t state_q;
	logic signed [DW-1:0] di_q, dj_q;

	logic                          v_s1, v_s2, ctr_s1, oob_s1;
	logic [gb2d_pkg::WT_W-1:0]     wt_s1;
	logic [gb2d_pkg::PROD_W-1:0]   prod_s2 [LN];
	logic [ACC_W-1:0]              acc_q [LN];
	logic [gb2d_pkg::PIX_W-1:0]    centre_q;
	logic                          out_valid_q;
	gb2d_pkg::out_item_t           out_q;

	// Effective register values.
	logic [WW-1:0]              eff_w;
	logic [gb2d_pkg::ROW_W-1:0] eff_h;
	logic [gb2d_pkg::CH_W-1:0]  eff_c;
	logic [DW-1:0]              eff_r;
	logic signed [DW-1:0]       r_s;

	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		eff_h = (height_q == '0) ? gb2d_pkg::ROW_W'(1) : height_q;
		if (chans_q == '0) begin
			eff_c = gb2d_pkg::CH_W'(1);
		end else if (32'(chans_q) > MAX_CHANNELS) begin
			eff_c = gb2d_pkg::CH_W'(MAX_CHANNELS);
		end else begin
			eff_c = chans_q;
		end
		eff_r = (32'(radius_q) > MAX_RADIUS) ? DW'(MAX_RADIUS) : DW'(radius_q);
		r_s   = $signed(eff_r);
	end

	function automatic logic [gb2d_pkg::WGT_W-1:0] sel_weight(
		input logic [1:0]                 idx,
		input logic [gb2d_pkg::WGT_W-1:0] w0,
		input logic [gb2d_pkg::WGT_W-1:0] w1,
		input logic [gb2d_pkg::WGT_W-1:0] w2,
		input logic [gb2d_pkg::WGT_W-1:0] w3
	);
		logic [gb2d_pkg::WGT_W-1:0] res;
		case (idx)
			2'd0:    res = w0;
			2'd1:    res = w1;
			2'd2:    res = w2;
			default: res = w3;
		endcase
		return res;
	endfunction

	// Configuration port.
	logic cfg_we;
	gb2d_pkg::reg_idx_t cfg_idx;
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = gb2d_pkg::reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (cfg_idx)
			gb2d_pkg::REG_FRAME_WIDTH:   prdata = gb2d_pkg::DATA_W'(width_q);
			gb2d_pkg::REG_FRAME_HEIGHT:  prdata = gb2d_pkg::DATA_W'(height_q);
			gb2d_pkg::REG_CHANNEL_COUNT: prdata = gb2d_pkg::DATA_W'(chans_q);
			gb2d_pkg::REG_KERNEL_RADIUS: prdata = gb2d_pkg::DATA_W'(radius_q);
			gb2d_pkg::REG_WEIGHT_ZERO:   prdata = gb2d_pkg::DATA_W'(weight_zero_q);
			gb2d_pkg::REG_WEIGHT_ONE:    prdata = gb2d_pkg::DATA_W'(weight_one_q);
			gb2d_pkg::REG_WEIGHT_TWO:    prdata = gb2d_pkg::DATA_W'(weight_two_q);
			default:                     prdata = gb2d_pkg::DATA_W'(weight_three_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q        <= gb2d_pkg::FW_W'(640);
			height_q       <= gb2d_pkg::ROW_W'(480);
			chans_q        <= gb2d_pkg::CH_W'(3);
			radius_q       <= gb2d_pkg::RAD_W'(3);
			weight_zero_q  <= gb2d_pkg::WGT_W'(26112);
			weight_one_q   <= gb2d_pkg::WGT_W'(15837);
			weight_two_q   <= gb2d_pkg::WGT_W'(3534);
			weight_three_q <= gb2d_pkg::WGT_W'(290);
		end else if (cfg_we) begin
			case (cfg_idx)
				gb2d_pkg::REG_FRAME_WIDTH:   width_q  <= pwdata[gb2d_pkg::FW_W-1:0];
				gb2d_pkg::REG_FRAME_HEIGHT:  height_q <= pwdata[gb2d_pkg::ROW_W-1:0];
				gb2d_pkg::REG_CHANNEL_COUNT: chans_q  <= pwdata[gb2d_pkg::CH_W-1:0];
				gb2d_pkg::REG_KERNEL_RADIUS: radius_q <= pwdata[gb2d_pkg::RAD_W-1:0];
				gb2d_pkg::REG_WEIGHT_ZERO:   weight_zero_q  <= pwdata[gb2d_pkg::WGT_W-1:0];
				gb2d_pkg::REG_WEIGHT_ONE:    weight_one_q   <= pwdata[gb2d_pkg::WGT_W-1:0];
				gb2d_pkg::REG_WEIGHT_TWO:    weight_two_q   <= pwdata[gb2d_pkg::WGT_W-1:0];
				default:                     weight_three_q <= pwdata[gb2d_pkg::WGT_W-1:0];
			endcase
		end
	end

	// Input side: a pixel is stored unless the frame's input is already complete.
	logic pix_acc, pix_store;
	assign pix_ready = (state_q == S_IDLE);
	assign pix_acc   = pix_valid && pix_ready;
	assign pix_store = pix_acc && !pix.flush && (in_row_q < eff_h);

	// Readiness of the next output position.
	logic [NW-1:0] need_row, row_sum;
	logic [WW:0]   need_col, col_sum;
	logic          ready_out;
	always_comb begin
		row_sum  = NW'(out_row_q) + NW'(eff_r);
		need_row = (row_sum < NW'(eff_h) - NW'(1)) ? row_sum : NW'(eff_h) - NW'(1);
		col_sum  = (WW + 1)'(out_col_q) + (WW + 1)'(eff_r);
		need_col = (col_sum < (WW + 1)'(eff_w) - (WW + 1)'(1)) ? col_sum
			: (WW + 1)'(eff_w) - (WW + 1)'(1);
		ready_out = (NW'(in_row_q) > need_row)
			|| ((NW'(in_row_q) == need_row) && ((WW + 1)'(in_col_q) > need_col));
	end

	// Tap address generation.
	logic signed [TRW-1:0] tap_row;
	logic signed [TCW-1:0] tap_col;
	logic signed [RGW-1:0] tap_ring_s;
	logic [RW-1:0]         tap_ring;
	logic                  tap_in;
	logic [AW-1:0]         tap_addr, ctr_addr, wr_addr, rd_addr;
	logic signed [DW-1:0]  adi, adj;
	logic                  last_tap;

	always_comb begin
		tap_row    = $signed(TRW'(out_row_q)) + TRW'(di_q);
		tap_col    = $signed(TCW'(out_col_q)) + TCW'(dj_q);
		tap_in     = (tap_row >= 0) && (tap_row < $signed(TRW'(eff_h)))
			&& (tap_col >= 0) && (tap_col < $signed(TCW'(eff_w)));
		tap_ring_s = $signed(RGW'(out_ring_q)) + RGW'(di_q);
		if (tap_ring_s < 0) begin
			tap_ring_s = tap_ring_s + RGW'(RING);
		end else if (tap_ring_s >= $signed(RGW'(RING))) begin
			tap_ring_s = tap_ring_s - RGW'(RING);
		end
		tap_ring = tap_ring_s[RW-1:0];
		tap_addr = AW'(tap_ring) * AW'(MAX_WIDTH) + AW'(tap_col[CW-1:0]);
		ctr_addr = AW'(out_ring_q) * AW'(MAX_WIDTH) + AW'(out_col_q);
		wr_addr  = AW'(in_ring_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
		rd_addr  = (state_q == S_RUN && tap_in) ? tap_addr : ctr_addr;
		adi      = (di_q < 0) ? -di_q : di_q;
		adj      = (dj_q < 0) ? -dj_q : dj_q;
		last_tap = (di_q == r_s) && (dj_q == r_s);
	end

	logic [gb2d_pkg::PIX_W-1:0] rd_data, tap_pix;

	gb2d_ram #(
		.WIDTH (gb2d_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_lines (
		.clk   (clk),
		.we    (pix_store),
		.waddr (wr_addr),
		.wdata ({pix.chan_d, pix.chan_c, pix.chan_b, pix.chan_a}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign tap_pix = oob_s1 ? centre_q : rd_data;

	// Multiply-accumulate pipeline: weight product, channel product, sum.
	always_ff @(posedge clk) begin
		wt_s1 <= sel_weight(adi[1:0], weight_zero_q, weight_one_q, weight_two_q,
			weight_three_q)
			* sel_weight(adj[1:0], weight_zero_q, weight_one_q, weight_two_q,
			weight_three_q);
		oob_s1 <= !tap_in;
		if (ctr_s1) begin
			centre_q <= rd_data;
		end
		for (int k = 0; k < LN; k++) begin
			prod_s2[k] <= gb2d_pkg::PROD_W'(wt_s1) * gb2d_pkg::PROD_W'(tap_pix[CHW*k +: CHW]);
			if (state_q == S_CTR) begin
				acc_q[k] <= '0;
			end else if (v_s2) begin
				acc_q[k] <= acc_q[k] + ACC_W'(prod_s2[k]);
			end
		end
	end

	// Rounding and saturation of the finished sums; lanes beyond the channel count are zero.
	gb2d_pkg::out_item_t res;
	logic [ACC_W-1:0]    rnd [LN];
	logic [CHW-1:0]      lane [LN];
	logic                last_px;
	always_comb begin
		for (int k = 0; k < LN; k++) begin
			rnd[k] = acc_q[k] + (ACC_W'(1) << (gb2d_pkg::FRAC_W - 1));
			if (k >= int'(eff_c)) begin
				lane[k] = '0;
			end else if (|rnd[k][ACC_W-1:gb2d_pkg::FRAC_W+CHW]) begin
				lane[k] = '1;
			end else begin
				lane[k] = rnd[k][gb2d_pkg::FRAC_W +: CHW];
			end
		end
		last_px = (WW'(out_col_q) == eff_w - WW'(1)) && (out_row_q == eff_h - gb2d_pkg::ROW_W'(1));
		res.blur_a       = lane[0];
		res.blur_b       = lane[1];
		res.blur_c       = lane[2];
		res.blur_d       = lane[3];
		res.end_of_frame = last_px;
	end

	logic done_go;
	assign done_go = (state_q == S_DONE) && (!out_valid_q || blur_ready);

	// Sequencer and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			di_q       <= '0;
			dj_q       <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			ctr_s1     <= 1'b0;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_ring_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_ring_q <= '0;
		end else begin
			v_s1   <= (state_q == S_RUN);
			v_s2   <= v_s1;
			ctr_s1 <= (state_q == S_CTR);
			case (state_q)
				S_IDLE: begin
					if (pix_acc) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= ready_out ? S_CTR : S_IDLE;
					di_q    <= -r_s;
					dj_q    <= -r_s;
				end
				S_CTR: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (last_tap) begin
						state_q <= S_DRAIN;
					end
					if (dj_q == r_s) begin
						dj_q <= -r_s;
						di_q <= di_q + DW'(1);
					end else begin
						dj_q <= dj_q + DW'(1);
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (done_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_we || (done_go && last_px)) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_ring_q  <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_ring_q <= '0;
			end else begin
				if (pix_store) begin
					if (WW'(in_col_q) + WW'(1) >= eff_w) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + gb2d_pkg::ROW_W'(1);
						in_ring_q <= (32'(in_ring_q) == RING - 1) ? '0 : in_ring_q + RW'(1);
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
				end
				if (done_go) begin
					if (WW'(out_col_q) + WW'(1) >= eff_w) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + gb2d_pkg::ROW_W'(1);
						out_ring_q <= (32'(out_ring_q) == RING - 1) ? '0 : out_ring_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (blur_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			out_q <= res;
		end
	end

	assign blur_valid = out_valid_q;
	assign blur       = out_q;

	// The accumulation pipeline is empty whenever a new beat can be taken.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!v_s1 && !v_s2))
		else $error("pipeline busy while idle");

	// The line RAM is only written while no window is being read.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pix_store |-> (state_q == S_IDLE))
		else $error("line write during window read");

	// Outputs never run ahead of the input rows.
	a_out_behind: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q <= in_row_q)
		else $error("output row ahead of input row");

	// A finished result always lands in the output register.
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		done_go |=> out_valid_q)
		else $error("result lost");

endmodule
`default_nettype wire
